// ===== rtl/parallel_led_string_frame_driver_top_defines.svh =====
// ----------------------------------------------------------------------------
// parallel_led_string_frame_driver_top_defines.svh
// Assertion macros used by the frame driver checker.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_LED_STRING_FRAME_DRIVER_TOP_DEFINES_SVH
`define PARALLEL_LED_STRING_FRAME_DRIVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PLSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plsd check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during reset
`define PLSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plsd check failed: next-cycle rule");

`endif

// ===== rtl/plsd_pkg.sv =====
// ----------------------------------------------------------------------------
// plsd_pkg
// Shared sizes, codes and command types of the LED string frame driver.
// ----------------------------------------------------------------------------
package plsd_pkg;

    // String geometry
    localparam int LIGHTS  = 24;
    localparam int STRINGS = 48;
    localparam int HALF    = STRINGS / 2;

    // Beat field widths
    localparam int REQ_W    = 2;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 6;
    localparam int COLOR_W  = 12;
    localparam int LEVEL_W  = 48;
    localparam int BRIGHT_W = 8;
    localparam int GAP_W    = 4;

    // Datagram layout
    localparam int DATA_BITS        = 26;
    localparam int ADDR_W           = 6;
    localparam int HI_W             = ADDR_W + BRIGHT_W;
    localparam int LIGHT_BASE_SLOTS = 1 + 3 * DATA_BITS;

    // Derived widths
    localparam int LIGHT_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int STR_W   = (STRINGS > 1) ? $clog2(STRINGS) : 1;
    localparam int SLOT_W  = $clog2(LIGHT_BASE_SLOTS + 16);
    localparam int BIT_W   = $clog2(DATA_BITS + 1);
    localparam int CIDX_W  = $clog2(COLOR_W);
    localparam int HIDX_W  = $clog2(HI_W);

    // Register port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd204;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 4'd6;

    typedef enum logic [0:0] {
        REG_BRIGHTNESS = 1'b0,
        REG_GAP_SLOTS  = 1'b1
    } reg_idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_START = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    // Line level of one slot
    typedef enum logic [1:0] {
        SK_ZERO = 2'd0,
        SK_ONE  = 2'd1,
        SK_DATA = 2'd2
    } slot_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic                 wr_en;
        logic                 clr_en;
        logic [LIGHT_W-1:0]   clr_row;
        logic                 out_load;
        logic                 emit;
        logic [LIGHT_W-1:0]   light;
        logic [BIT_W-1:0]     bit_idx;
        slot_kind_t           kind;
        logic                 busy;
        logic                 done;
        logic                 rej;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic coord_ok;
    } dp_stat_t;

endpackage

// ===== rtl/plsd_req_if.sv =====
// ----------------------------------------------------------------------------
// plsd_req_if
// Request channel: write, clear, start and tick beats.
// ----------------------------------------------------------------------------
interface plsd_req_if;
    logic                         valid;
    logic                         ready;
    logic [plsd_pkg::REQ_W-1:0]   req_type;
    logic [plsd_pkg::ROW_W-1:0]   row;
    logic [plsd_pkg::COL_W-1:0]   col;
    logic [plsd_pkg::COLOR_W-1:0] color;

    modport source (output valid, req_type, row, col, color, input ready);
    modport sink   (input valid, req_type, row, col, color, output ready);
endinterface

// ===== rtl/plsd_res_if.sv =====
// ----------------------------------------------------------------------------
// plsd_res_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface plsd_res_if;
    logic                         valid;
    logic                         ready;
    logic [plsd_pkg::LEVEL_W-1:0] line_levels;
    logic                         busy_res;
    logic                         frame_done;
    logic                         rejected;

    modport source (output valid, line_levels, busy_res, frame_done, rejected, input ready);
    modport sink   (input valid, line_levels, busy_res, frame_done, rejected, output ready);
endinterface

// ===== rtl/plsd_ram.sv =====
// ----------------------------------------------------------------------------
// plsd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module plsd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 24
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/plsd_cfg.sv =====
// ----------------------------------------------------------------------------
// plsd_cfg
// APB register file: brightness byte and gap slot count.
// ----------------------------------------------------------------------------
module plsd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plsd_pkg::PADDR_W-1:0]    paddr,
    input  logic [plsd_pkg::PDATA_W-1:0]    pwdata,
    output logic [plsd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output logic [plsd_pkg::BRIGHT_W-1:0]   brightness,
    output logic [plsd_pkg::GAP_W-1:0]      gap_slots
);

    logic [plsd_pkg::BRIGHT_W-1:0] bright_reg;
    logic [plsd_pkg::GAP_W-1:0]    gap_reg;
    logic                          wr_hit;
    plsd_pkg::reg_idx_t            reg_sel;

    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite;
    assign reg_sel = plsd_pkg::reg_idx_t'(paddr[plsd_pkg::PADDR_W-1:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= plsd_pkg::BRIGHT_RESET;
            gap_reg    <= plsd_pkg::GAP_RESET;
        end
        else if (wr_hit)
        begin
            case (reg_sel)
                plsd_pkg::REG_BRIGHTNESS: bright_reg <= pwdata[plsd_pkg::BRIGHT_W-1:0];
                plsd_pkg::REG_GAP_SLOTS:  gap_reg    <= pwdata[plsd_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            plsd_pkg::REG_BRIGHTNESS: prdata = plsd_pkg::PDATA_W'(bright_reg);
            plsd_pkg::REG_GAP_SLOTS:  prdata = plsd_pkg::PDATA_W'(gap_reg);
            default:                  prdata = '0;
        endcase
    end

    assign brightness = bright_reg;
    assign gap_slots  = gap_reg;

endmodule

// ===== rtl/plsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// plsd_ctrl
// Sequencer: request handshake, store clearing pass and slot counters.
// ----------------------------------------------------------------------------
module plsd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [plsd_pkg::REQ_W-1:0]    req_type,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic [plsd_pkg::GAP_W-1:0]    gap_slots,
    input  plsd_pkg::dp_stat_t            stat,
    output plsd_pkg::dp_cmd_t             cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_DATA,
        PH_HIGH
    } phase_t;

    state_t                          state_reg,   state_next;
    phase_t                          phase_reg,   phase_next;
    logic [plsd_pkg::LIGHT_W-1:0]    light_reg,   light_next;
    logic [plsd_pkg::SLOT_W-1:0]     slot_reg,    slot_next;
    logic [plsd_pkg::BIT_W-1:0]      bit_reg,     bit_next;
    logic [plsd_pkg::LIGHT_W-1:0]    clr_row_reg, clr_row_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            accept;
    logic                            sending;
    logic [plsd_pkg::SLOT_W-1:0]     slot_inc;
    logic [plsd_pkg::SLOT_W-1:0]     light_slots;
    plsd_pkg::slot_kind_t            kind;

    assign sending     = (state_reg == ST_SEND);
    assign in_ready    = (state_reg != ST_CLEAR) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign slot_inc    = slot_reg + 1'b1;
    assign light_slots = plsd_pkg::SLOT_W'(plsd_pkg::LIGHT_BASE_SLOTS)
                       + plsd_pkg::SLOT_W'(gap_slots);

    // Level kind of the current slot
    always_comb
    begin
        kind = plsd_pkg::SK_ZERO;
        if (slot_reg == '0)
        begin
            kind = plsd_pkg::SK_ONE;
        end
        else if (bit_reg == plsd_pkg::BIT_W'(plsd_pkg::DATA_BITS))
        begin
            kind = plsd_pkg::SK_ZERO;
        end
        else
        begin
            case (phase_reg)
                PH_LOW:  kind = plsd_pkg::SK_ZERO;
                PH_DATA: kind = plsd_pkg::SK_DATA;
                PH_HIGH: kind = plsd_pkg::SK_ONE;
                default: kind = plsd_pkg::SK_ZERO;
            endcase
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        light_next     = light_reg;
        slot_next      = slot_reg;
        bit_next       = bit_reg;
        clr_row_next   = clr_row_reg;
        out_valid_next = out_valid_reg;

        cmd          = '0;
        cmd.clr_row  = clr_row_reg;
        cmd.light    = light_reg;
        cmd.bit_idx  = bit_reg;
        cmd.kind     = kind;
        cmd.out_load = accept;

        // clearing pass: one row of every string per cycle
        if (state_reg == ST_CLEAR)
        begin
            cmd.clr_en = 1'b1;
            if (clr_row_reg == plsd_pkg::LIGHT_W'(plsd_pkg::LIGHTS - 1))
            begin
                state_next   = ST_IDLE;
                clr_row_next = '0;
            end
            else
            begin
                clr_row_next = clr_row_reg + 1'b1;
            end
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            case (plsd_pkg::req_t'(req_type))
                plsd_pkg::REQ_WRITE:
                begin
                    cmd.rej   = sending || !stat.coord_ok;
                    cmd.wr_en = !(sending || !stat.coord_ok);
                    cmd.busy  = sending;
                end
                plsd_pkg::REQ_CLEAR:
                begin
                    cmd.rej  = sending;
                    cmd.busy = sending;
                    if (!sending)
                    begin
                        state_next   = ST_CLEAR;
                        clr_row_next = '0;
                    end
                end
                plsd_pkg::REQ_START:
                begin
                    cmd.rej  = sending;
                    cmd.busy = 1'b1;
                    if (!sending)
                    begin
                        state_next = ST_SEND;
                        light_next = '0;
                        slot_next  = '0;
                        bit_next   = '0;
                        phase_next = PH_LOW;
                    end
                end
                plsd_pkg::REQ_TICK:
                begin
                    if (sending)
                    begin
                        cmd.emit = 1'b1;
                        cmd.busy = 1'b1;
                        if (slot_inc >= light_slots)
                        begin
                            // end of this light's datagram and gap
                            slot_next  = '0;
                            bit_next   = '0;
                            phase_next = PH_LOW;
                            if (light_reg == plsd_pkg::LIGHT_W'(plsd_pkg::LIGHTS - 1))
                            begin
                                light_next = '0;
                                state_next = ST_IDLE;
                                cmd.done   = 1'b1;
                            end
                            else
                            begin
                                light_next = light_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            slot_next = slot_inc;
                            // bit phases advance after the start slot, hold in the gap
                            if ((slot_reg != '0)
                                && (bit_reg != plsd_pkg::BIT_W'(plsd_pkg::DATA_BITS)))
                            begin
                                case (phase_reg)
                                    PH_LOW:  phase_next = PH_DATA;
                                    PH_DATA: phase_next = PH_HIGH;
                                    PH_HIGH:
                                    begin
                                        phase_next = PH_LOW;
                                        bit_next   = bit_reg + 1'b1;
                                    end
                                    default: phase_next = PH_LOW;
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_LOW;
            light_reg     <= '0;
            slot_reg      <= '0;
            bit_reg       <= '0;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            light_reg     <= light_next;
            slot_reg      <= slot_next;
            bit_reg       <= bit_next;
            clr_row_reg   <= clr_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/plsd_dp.sv =====
// ----------------------------------------------------------------------------
// plsd_dp
// Datapath: per-string colour RAMs, coordinate decode, slot level logic
// and the result register.
// ----------------------------------------------------------------------------
module plsd_dp (
    input  logic                            clk,
    input  plsd_pkg::dp_cmd_t               cmd,
    input  logic [plsd_pkg::ROW_W-1:0]      row,
    input  logic [plsd_pkg::COL_W-1:0]      col,
    input  logic [plsd_pkg::COLOR_W-1:0]    color,
    input  logic [plsd_pkg::BRIGHT_W-1:0]   brightness,
    output plsd_pkg::dp_stat_t              stat,
    output logic [plsd_pkg::LEVEL_W-1:0]    line_levels,
    output logic                            busy_res,
    output logic                            frame_done,
    output logic                            rejected
);

    logic                             right;
    logic [plsd_pkg::STR_W-1:0]       str_idx;
    logic [plsd_pkg::COL_W-1:0]       col_off;
    logic [plsd_pkg::LIGHT_W-1:0]     col_idx;
    logic [plsd_pkg::LIGHT_W-1:0]     waddr;
    logic [plsd_pkg::LIGHT_W-1:0]     raddr;
    logic [plsd_pkg::COLOR_W-1:0]     wdata;
    logic [plsd_pkg::COLOR_W-1:0]     rd_data [plsd_pkg::STRINGS];

    logic [plsd_pkg::ADDR_W-1:0]      light_addr;
    logic [plsd_pkg::HI_W-1:0]        word_hi;
    logic [plsd_pkg::BIT_W-1:0]       rev_idx;
    logic [plsd_pkg::BIT_W-1:0]       hi_pos;
    logic                             use_colour;
    logic                             common_bit;
    logic [plsd_pkg::CIDX_W-1:0]      cidx;

    logic [plsd_pkg::STRINGS-1:0]     levels;
    logic [plsd_pkg::LEVEL_W-1:0]     levels_vis;

    logic [plsd_pkg::LEVEL_W-1:0]     levels_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic                             rej_reg;

    // Coordinate decode for pixel writes
    assign stat.coord_ok = (row >= plsd_pkg::ROW_W'(1))
                        && (row <= plsd_pkg::ROW_W'(plsd_pkg::HALF))
                        && (col >= plsd_pkg::COL_W'(1))
                        && (col <= plsd_pkg::COL_W'(2 * plsd_pkg::LIGHTS));
    assign right   = col > plsd_pkg::COL_W'(plsd_pkg::LIGHTS);
    assign str_idx = plsd_pkg::STR_W'(row - 1'b1)
                   + (right ? plsd_pkg::STR_W'(plsd_pkg::HALF) : '0);
    assign col_off = right ? (col - plsd_pkg::COL_W'(plsd_pkg::LIGHTS + 1))
                           : (col - plsd_pkg::COL_W'(1));
    assign col_idx = col_off[plsd_pkg::LIGHT_W-1:0];

    // Store ports: clearing pass writes zero to a row of every string
    assign waddr = cmd.clr_en ? cmd.clr_row : col_idx;
    assign wdata = cmd.clr_en ? '0 : color;
    assign raddr = plsd_pkg::LIGHT_W'(plsd_pkg::LIGHTS - 1) - cmd.light;

    // Bit selection within the 26-bit datagram, MSB first
    assign light_addr = plsd_pkg::ADDR_W'(plsd_pkg::LIGHTS) - plsd_pkg::ADDR_W'(cmd.light);
    assign word_hi    = {light_addr, brightness};
    assign rev_idx    = plsd_pkg::BIT_W'(plsd_pkg::DATA_BITS - 1) - cmd.bit_idx;
    assign use_colour = rev_idx < plsd_pkg::BIT_W'(plsd_pkg::COLOR_W);
    assign hi_pos     = rev_idx - plsd_pkg::BIT_W'(plsd_pkg::COLOR_W);
    assign cidx       = rev_idx[plsd_pkg::CIDX_W-1:0];
    assign common_bit = (hi_pos < plsd_pkg::BIT_W'(plsd_pkg::HI_W))
                      ? word_hi[hi_pos[plsd_pkg::HIDX_W-1:0]] : 1'b0;

    // One RAM and one level lane per string
    for (genvar s = 0; s < plsd_pkg::STRINGS; s++)
    begin : g_str
        logic data_bit;

        plsd_ram #(
            .WIDTH (plsd_pkg::COLOR_W),
            .DEPTH (plsd_pkg::LIGHTS)
        ) u_ram (
            .clk   (clk),
            .we    (cmd.clr_en || (cmd.wr_en && (str_idx == plsd_pkg::STR_W'(s)))),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (rd_data[s])
        );

        assign data_bit  = use_colour ? rd_data[s][cidx] : common_bit;
        assign levels[s] = (cmd.kind == plsd_pkg::SK_ONE)
                        || ((cmd.kind == plsd_pkg::SK_DATA) && !data_bit);
    end

    // Output bits beyond the strings read low; strings beyond the field are dropped
    for (genvar i = 0; i < plsd_pkg::LEVEL_W; i++)
    begin : g_vis
        if (i < plsd_pkg::STRINGS)
        begin : g_on
            assign levels_vis[i] = levels[i];
        end
        else
        begin : g_off
            assign levels_vis[i] = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            levels_reg <= cmd.emit ? levels_vis : '0;
            busy_reg   <= cmd.busy;
            done_reg   <= cmd.done;
            rej_reg    <= cmd.rej;
        end
    end

    assign line_levels = levels_reg;
    assign busy_res    = busy_reg;
    assign frame_done  = done_reg;
    assign rejected    = rej_reg;

endmodule

// ===== rtl/parallel_led_string_frame_driver_top.sv =====
// ----------------------------------------------------------------------------
// parallel_led_string_frame_driver_top
// Latency: a result beat is valid the cycle after its request beat is taken.
// Throughput: one request per cycle while results are taken; a waiting result
// holds off the next request.
// Reset and a store clear run a clearing pass (one light row of all 48 string
// RAMs per cycle) during which no request is taken.
// ----------------------------------------------------------------------------
module parallel_led_string_frame_driver_top (
    input  logic                            clk,
    input  logic                            rst_n,
    plsd_req_if.sink                        req,
    plsd_res_if.source                      res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plsd_pkg::PADDR_W-1:0]    paddr,
    input  logic [plsd_pkg::PDATA_W-1:0]    pwdata,
    output logic [plsd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [plsd_pkg::BRIGHT_W-1:0] brightness;
    logic [plsd_pkg::GAP_W-1:0]    gap_slots;
    plsd_pkg::dp_cmd_t             cmd;
    plsd_pkg::dp_stat_t            stat;

    // Configuration registers
    plsd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .brightness (brightness),
        .gap_slots  (gap_slots)
    );

    // Sequencer
    plsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req_type  (req.req_type),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .gap_slots (gap_slots),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store and level datapath
    plsd_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .row         (req.row),
        .col         (req.col),
        .color       (req.color),
        .brightness  (brightness),
        .stat        (stat),
        .line_levels (res.line_levels),
        .busy_res    (res.busy_res),
        .frame_done  (res.frame_done),
        .rejected    (res.rejected)
    );

endmodule

// ===== rtl/plsd_chk.sv =====
// ----------------------------------------------------------------------------
// plsd_chk
// Port-level checks of the frame driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "parallel_led_string_frame_driver_top_defines.svh"

module plsd_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [plsd_pkg::REQ_W-1:0]    req_type,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [plsd_pkg::LEVEL_W-1:0]  line_levels,
    input logic                          busy_res,
    input logic                          frame_done,
    input logic                          rejected
);

    // A finished frame is reported on a busy, accepted tick
    `PLSD_ASSERT_NOW(a_done_busy, res_valid && frame_done, busy_res && !rejected)

    // Ignored requests never drive the lines
    `PLSD_ASSERT_NOW(a_rej_quiet, res_valid && rejected, line_levels == '0)

    // An accepted clear blocks requests while the store is wiped
    `PLSD_ASSERT_NEXT(a_clr_block, req_valid && req_ready && (req_type == plsd_pkg::REQ_CLEAR), !req_ready || rejected)

    // Every taken request beat yields a result beat next cycle
    `PLSD_ASSERT_NEXT(a_res_follows, req_valid && req_ready, res_valid)

    // A stalled result beat stays
    `PLSD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

endmodule

bind parallel_led_string_frame_driver_top plsd_chk u_plsd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .line_levels (res.line_levels),
    .busy_res    (res.busy_res),
    .frame_done  (res.frame_done),
    .rejected    (res.rejected)
);

// ===== verif/parallel_led_string_frame_driver_top_test.sv =====
// ----------------------------------------------------------------------------
// parallel_led_string_frame_driver_top_test
// Self-checking bench for the 48-string LED frame driver. A directed table
// covers the coordinate limits, requests made during a frame and the first
// slots of a datagram. The frame it starts is run out at reset settings, then
// the registers are reprogrammed, the store is reloaded at random and a frame
// with no gap is sent across its first light boundaries. Every result beat is
// checked against its typed table row or else a cycle-free model of the line
// protocol. Both channels stall at random.
// ----------------------------------------------------------------------------
module parallel_led_string_frame_driver_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plsd_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 32;      // longer than the clearing pass
    localparam int LONG_HOLD     = 150;
    localparam int PART_TICKS    = 180;     // a little over two lights with no gap
    localparam int DRILL_N       = 25;
    localparam logic [LEVEL_W-1:0] ALL_HI   = '1;
    localparam logic [LEVEL_W-1:0] NO_LINES = '0;

    typedef struct packed {
        logic [LEVEL_W-1:0] levels;
        logic               busy;
        logic               done;
        logic               rej;
    } slot_res_t;

    typedef struct packed {
        req_t               kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COLOR_W-1:0] color;
        logic               typed;
        slot_res_t          want;
    } drill_t;

    // Directed rows; typed rows carry their result, the rest use the predictor
    localparam drill_t DRILL [DRILL_N] = '{
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd1,  6'd1,  12'hFFF, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd24, 6'd48, 12'h000, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd24, 6'd24, 12'hABC, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd1,  6'd25, 12'h555, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd0,  6'd1,  12'h123, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b1}},
        '{REQ_WRITE, 5'd25, 6'd10, 12'h456, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b1}},
        '{REQ_WRITE, 5'd31, 6'd63, 12'hFFF, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b1}},
        '{REQ_WRITE, 5'd5,  6'd0,  12'h789, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b1}},
        '{REQ_WRITE, 5'd5,  6'd49, 12'h321, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b1}},
        '{REQ_CLEAR, 5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd12, 6'd37, 12'h7E1, 1'b0, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd3,  6'd3,  12'h800, 1'b0, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_WRITE, 5'd24, 6'd48, 12'hFFF, 1'b0, '{NO_LINES, 1'b0, 1'b0, 1'b0}},
        '{REQ_START, 5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b0}},
        '{REQ_START, 5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b1}},
        '{REQ_WRITE, 5'd2,  6'd2,  12'h0F0, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b1}},
        '{REQ_CLEAR, 5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b1}},
        // start slot, then the first two address bits of address 24 (zero, then one)
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{ALL_HI,   1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{ALL_HI,   1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{ALL_HI,   1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b1, '{NO_LINES, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK,  5'd0,  6'd0,  12'h000, 1'b0, '{NO_LINES, 1'b0, 1'b0, 1'b0}}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    plsd_req_if req_ch ();
    plsd_res_if res_ch ();

    parallel_led_string_frame_driver_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the driver: colour store, frame position, registers
    logic [COLOR_W-1:0]  shade_mem [STRINGS*LIGHTS];
    int unsigned         lamp_idx;
    int unsigned         slot_idx;
    bit                  frame_on;
    logic [BRIGHT_W-1:0] cur_bright;
    logic [GAP_W-1:0]    cur_gap;

    slot_res_t pending_slots [$];
    int        errors;
    int        beats_taken;
    int        frames_sent;
    int        rejects_seen;
    int        reg_writes;
    int        cycle_cnt;
    int        hold_off_req;
    bit        src_calm;
    bit        sink_calm;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mismatch log
    task automatic flag_miss(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Line levels of the current slot of the current light
    function automatic logic [LEVEL_W-1:0] slot_lines();
        logic [LEVEL_W-1:0]   lv;
        logic [ADDR_W-1:0]    addr;
        logic [DATA_BITS-1:0] word;
        int unsigned          b;
        int unsigned          ph;
        int                   st;
        lv   = '0;
        addr = ADDR_W'(LIGHTS - lamp_idx);
        if (slot_idx == 0)
            return ALL_HI;
        if (slot_idx > 3 * DATA_BITS)
            return '0;
        b  = (slot_idx - 1) / 3;
        ph = (slot_idx - 1) % 3;
        if (ph == 0)
            return '0;
        if (ph == 2)
            return ALL_HI;
        // middle third: high for a zero bit, low for a one bit
        for (st = 0; st < STRINGS; st++)
        begin
            word   = {addr, cur_bright, shade_mem[st * LIGHTS + int'(addr) - 1]};
            lv[st] = ~word[DATA_BITS - 1 - b];
        end
        return lv;
    endfunction

    // Apply one request beat to the shadow and return its result beat
    function automatic slot_res_t next_slot(input req_t kind,
                                            input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col,
                                            input logic [COLOR_W-1:0] color);
        slot_res_t   r;
        int unsigned st;
        int unsigned c;
        bit          right;
        r = '0;
        case (kind)
            REQ_WRITE:
            begin
                if (frame_on || row < 1 || row > HALF || col < 1 || col > 2 * LIGHTS)
                    r.rej = 1'b1;
                else
                begin
                    right = col > LIGHTS;
                    st    = int'(row) - 1 + (right ? HALF : 0);
                    c     = right ? int'(col) - LIGHTS : int'(col);
                    shade_mem[st * LIGHTS + c - 1] = color;
                end
                r.busy = frame_on;
            end
            REQ_CLEAR:
            begin
                if (frame_on)
                    r.rej = 1'b1;
                else
                    foreach (shade_mem[i])
                        shade_mem[i] = '0;
                r.busy = frame_on;
            end
            REQ_START:
            begin
                if (frame_on)
                    r.rej = 1'b1;
                else
                begin
                    frame_on = 1'b1;
                    lamp_idx = 0;
                    slot_idx = 0;
                end
                r.busy = 1'b1;
            end
            default:
            begin
                // tick: idle ticks leave everything low
                if (frame_on)
                begin
                    r.busy   = 1'b1;
                    r.levels = slot_lines();
                    slot_idx++;
                    if (slot_idx >= 1 + 3 * DATA_BITS + cur_gap)
                    begin
                        slot_idx = 0;
                        lamp_idx++;
                        if (lamp_idx >= LIGHTS)
                        begin
                            lamp_idx = 0;
                            frame_on = 1'b0;
                            r.done   = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request beat; predict it when taken
    task automatic push_req(input req_t kind,
                            input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col,
                            input logic [COLOR_W-1:0] color,
                            input bit typed = 1'b0,
                            input slot_res_t want = '0);
        int        waits;
        slot_res_t guess;
        waits = draw_wait(src_calm);
        repeat (waits)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid    = 1'b1;
        req_ch.req_type = kind;
        req_ch.row      = row;
        req_ch.col      = col;
        req_ch.color    = color;
        do
            @(posedge clk);
        while (!req_ch.ready);
        guess = next_slot(kind, row, col, color);
        pending_slots.push_back(typed ? want : guess);
        beats_taken++;
        if (guess.done)
            frames_sent++;
        if (guess.rej)
            rejects_seen++;
        if (beats_taken % 50 == 0)
            src_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write with read-back
    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] got;
        mask = (idx == REG_BRIGHTNESS) ? PDATA_W'(8'hFF) : PDATA_W'(4'hF);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(int'(idx) * 4);
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if ((got & mask) !== (val & mask))
            flag_miss($sformatf("register %s read %h wrote %h", idx.name(), got, val));
        if (idx == REG_BRIGHTNESS)
            cur_bright = val[BRIGHT_W-1:0];
        else
            cur_gap = val[GAP_W-1:0];
        reg_writes++;
    endtask

    // Pixel loads: mostly in range, some with any coordinates or a clear
    task automatic fill_store(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 9) != 0)
                push_req(REQ_WRITE, ROW_W'($urandom_range(1, HALF)),
                         COL_W'($urandom_range(1, 2 * LIGHTS)),
                         COLOR_W'($urandom_range(0, 4095)));
            else if ($urandom_range(0, 7) != 0)
                push_req(REQ_WRITE, ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 63)),
                         COLOR_W'($urandom_range(0, 4095)));
            else
                push_req(REQ_CLEAR, ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 63)),
                         COLOR_W'($urandom_range(0, 4095)));
        end
    endtask

    // Tick until the frame is out, with stray requests in between
    task automatic run_out_frame();
        while (frame_on)
        begin
            if ($urandom_range(0, 19) == 0)
                push_req(req_t'($urandom_range(0, 2)), ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));
            else
                push_req(REQ_TICK, ROW_W'($urandom_range(0, 31)),
                         COL_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));
            if ($urandom_range(0, 999) == 0)
                settle();
        end
    endtask

    // Result receiver: random stalls plus one long hold-off on request
    initial
    begin : sink_side
        int waits;
        int taken;
        taken        = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req > 0)
            begin
                waits        = hold_off_req;
                hold_off_req = 0;
            end
            else
                waits = draw_wait(sink_calm);
            repeat (waits)
            begin
                @(negedge clk);
                res_ch.ready = 1'b0;
            end
            @(negedge clk);
            res_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken++;
            if (taken % 40 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin : res_check
        slot_res_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_slots.size() == 0)
                flag_miss("result beat with nothing expected");
            else
            begin
                want = pending_slots.pop_front();
                if (res_ch.line_levels !== want.levels)
                    flag_miss($sformatf("line_levels %h, expected %h",
                                        res_ch.line_levels, want.levels));
                if (res_ch.busy_res !== want.busy)
                    flag_miss($sformatf("busy_res %b, expected %b",
                                        res_ch.busy_res, want.busy));
                if (res_ch.frame_done !== want.done)
                    flag_miss($sformatf("frame_done %b, expected %b",
                                        res_ch.frame_done, want.done));
                if (res_ch.rejected !== want.rej)
                    flag_miss($sformatf("rejected %b, expected %b",
                                        res_ch.rejected, want.rej));
            end
        end
    end

    // Stimulus
    initial
    begin
        int                  i;
        logic [BRIGHT_W-1:0] bright_v;
        logic [GAP_W-1:0]    gap_v;
        errors          = 0;
        beats_taken     = 0;
        frames_sent     = 0;
        rejects_seen    = 0;
        reg_writes      = 0;
        cycle_cnt       = 0;
        hold_off_req    = 0;
        src_calm        = 1'b0;
        sink_calm       = 1'b0;
        foreach (shade_mem[k])
            shade_mem[k] = '0;
        lamp_idx        = 0;
        slot_idx        = 0;
        frame_on        = 1'b0;
        cur_bright      = BRIGHT_RESET;
        cur_gap         = GAP_RESET;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.row      = '0;
        req_ch.col      = '0;
        req_ch.color    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, reset register values
        for (i = 0; i < DRILL_N; i++)
            push_req(DRILL[i].kind, DRILL[i].row, DRILL[i].col, DRILL[i].color,
                     DRILL[i].typed, DRILL[i].want);

        // Finish the frame the table started, still at reset settings
        run_out_frame();
        settle();

        // Reprogram: random brightness, no gap at all
        bright_v = BRIGHT_W'($urandom_range(0, 255));
        gap_v    = 4'd0;
        reg_write(REG_BRIGHTNESS, PDATA_W'(bright_v));
        reg_write(REG_GAP_SLOTS, PDATA_W'(gap_v));

        // long receiver stall while requests keep coming
        hold_off_req = LONG_HOLD;
        src_calm     = 1'b1;
        fill_store($urandom_range(30, 60));
        push_req(REQ_CLEAR, '0, '0, '0);
        fill_store($urandom_range(30, 60));

        // First lights of a frame with no gap, across two light boundaries
        push_req(REQ_START, ROW_W'($urandom_range(0, 31)),
                 COL_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));
        repeat (PART_TICKS)
            push_req(REQ_TICK, ROW_W'($urandom_range(0, 31)),
                     COL_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));

        // Loose mix of every request type
        repeat (60)
            push_req(req_t'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 31)),
                     COL_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 4095)));

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d request beats, %0d full frames, %0d rejected requests",
                 beats_taken, frames_sent, rejects_seen);
        $display("%0d register writes; a full frame at reset settings, part of one with no gap",
                 reg_writes);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/plsd_pkg.sv
rtl/plsd_req_if.sv
rtl/plsd_res_if.sv
rtl/plsd_ram.sv
rtl/plsd_cfg.sv
rtl/plsd_ctrl.sv
rtl/plsd_dp.sv
rtl/parallel_led_string_frame_driver_top.sv
rtl/plsd_chk.sv
verif/parallel_led_string_frame_driver_top_test.sv
